/* rtl/conv3x3_sobel_mean_removal_defines.svh */
// Assertion macros for the 3x3 convolution filter
`ifndef CONV3X3_SOBEL_MEAN_REMOVAL_DEFINES_SVH
`define CONV3X3_SOBEL_MEAN_REMOVAL_DEFINES_SVH

// Checked at every clock edge outside reset
`define CSMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included
`define CSMR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/csmr_pkg.sv */
// Types, register codes and the kernel arithmetic of the 3x3 convolution filter
`timescale 1ns / 1ps

package csmr_pkg;

	localparam int PIX_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int SUM_W    = 13;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic KSEL_SOBEL = 1'b0;
	localparam logic KSEL_MEAN  = 1'b1;
	localparam logic KSEL_RESET = KSEL_SOBEL;

	localparam logic signed [SUM_W-1:0] SOBEL_OFFSET = 13'sd127;
	localparam logic signed [SUM_W-1:0] MEAN_CENTRE  = 13'sd9;
	localparam logic signed [SUM_W-1:0] PIX_MAX      = 13'sd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_SELECT = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2
	} cfg_reg_t;

	// row-major: [0..2] top row, [3..5] middle, [6..8] bottom
	typedef logic [8:0][PIX_W-1:0] win_t;

	function automatic logic [PIX_W-1:0] convolve(input logic ksel, input win_t g);
		logic signed [SUM_W-1:0] e [9];
		logic signed [SUM_W-1:0] s;
		logic [PIX_W-1:0] res;
		for (int i = 0; i < 9; i++) begin
			e[i] = $signed({{(SUM_W-PIX_W){1'b0}}, g[i]});
		end
		if (ksel == KSEL_MEAN) begin
			s = MEAN_CENTRE * e[4]
				- (e[0] + e[1] + e[2] + e[3] + e[5] + e[6] + e[7] + e[8]);
		end else begin
			s = e[0] - e[2] + e[3] + e[3] - e[5] - e[5] + e[6] - e[8] + SOBEL_OFFSET;
		end
		if (s < 0) begin
			res = '0;
		end else if (s > PIX_MAX) begin
			res = '1;
		end else begin
			res = s[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/conv3x3_sobel_mean_removal.sv */
// 3x3 convolution filter (horizontal Sobel or mean removal) over a raster pixel stream
`timescale 1ns / 1ps

// Takes one pixel per clock unless stalled and gives at most one filtered pixel per
// accepted beat, so a full frame of H*W pixels plus W+1 drain beats streams at one beat
// per cycle unless stalled. Each beat passes through a capture stage, where the
// position counters advance and the two rows above are read from one 16-bit row memory
// of MAX_WIDTH entries, and a filter stage, where the 3x3 window shifts, the kernel sum
// is clamped into the output register and the row memory is written back. The row
// memory is not cleared: rows above the image are masked by the row counter. Input
// stall rises only while the output register holds a result that downstream stalls.
`include "conv3x3_sobel_mean_removal_defines.svh"

module conv3x3_sobel_mean_removal #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [csmr_pkg::PIX_W-1:0]         pixel,
	input  logic                               drain,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [csmr_pkg::PIX_W-1:0]         filtered_pixel,
	output logic                               frame_last,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CW1 = $clog2(MAX_WIDTH + 1);
	localparam int RH1 = $clog2(MAX_HEIGHT + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int PW  = csmr_pkg::PIX_W;

	// configuration
	logic                               kernel_select_q;
	logic [csmr_pkg::WIDTH_W-1:0]       image_width_q;
	logic [csmr_pkg::HEIGHT_W-1:0]      image_height_q;
	logic [CW1-1:0]                     w_eff;
	logic [RH1-1:0]                     h_eff;

	// capture stage
	logic [CW-1:0]                      col_q;
	logic [RW-1:0]                      row_q;
	logic                               adv;
	logic                               acc;
	logic                               first_c;
	logic                               last_c;
	logic                               wrap_c;

	// filter stage
	logic                               valid_s1;
	logic [PW-1:0]                      v_s1;
	logic [CW-1:0]                      c_s1;
	logic                               first_s1;
	logic                               last_s1;
	logic                               ge1_s1;
	logic                               ge2_s1;
	logic [2*PW-1:0]                    rd_s1;
	logic                               fwd_s1;
	logic [2*PW-1:0]                    fwd_data_s1;
	logic [2*PW-1:0]                    rows_cur;
	logic [PW-1:0]                      a_cur;
	logic [PW-1:0]                      b_cur;
	logic                               proc;
	logic                               wr_en;
	logic                               fwd_next;
	logic                               emit;
	csmr_pkg::win_t                     win_q;
	csmr_pkg::win_t                     win_next;
	csmr_pkg::win_t                     conv_in;

	// result register
	logic                               out_valid_q;
	logic [PW-1:0]                      filtered_q;
	logic                               frame_last_q;

	// row store: {upper, middle} per column
	logic [2*PW-1:0]                    row_mem [MAX_WIDTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_select_q <= csmr_pkg::KSEL_RESET;
			image_width_q   <= csmr_pkg::WIDTH_RESET;
			image_height_q  <= csmr_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (csmr_pkg::cfg_reg_t'(cfg_index))
				csmr_pkg::REG_KERNEL_SELECT: kernel_select_q <= cfg_data[0];
				csmr_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[csmr_pkg::WIDTH_W-1:0];
				csmr_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[csmr_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero means one, oversize means the maximum
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = CW1'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW1'(MAX_WIDTH);
		end else begin
			w_eff = CW1'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = RH1'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = RH1'(MAX_HEIGHT);
		end else begin
			h_eff = RH1'(image_height_q);
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	assign first_c = (col_q == '0);
	assign last_c  = first_c && (row_q >= RW'(h_eff) + RW'(1));
	assign wrap_c  = (CW1'(col_q) + CW1'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_c) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1        <= (drain || row_q >= RW'(h_eff)) ? '0 : pixel;
			c_s1        <= col_q;
			first_s1    <= first_c;
			last_s1     <= last_c;
			ge1_s1      <= (row_q != '0);
			ge2_s1      <= (row_q > RW'(1));
			fwd_s1      <= fwd_next;
			fwd_data_s1 <= {b_cur, v_s1};
		end
	end

	assign proc     = adv && valid_s1;
	assign wr_en    = proc && !last_s1;
	// same column read and written on one edge: take the value being written
	assign fwd_next = wr_en && acc && (c_s1 == col_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[c_s1] <= {b_cur, v_s1};
		end
		if (adv) begin
			rd_s1 <= row_mem[col_q];
		end
	end

	assign rows_cur = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign a_cur    = ge2_s1 ? rows_cur[2*PW-1:PW] : '0;
	assign b_cur    = ge1_s1 ? rows_cur[PW-1:0] : '0;

	always_comb begin
		conv_in  = win_q;
		win_next = win_q;
		if (first_s1) begin
			// close the previous row with a zero right column
			conv_in = {8'd0, win_q[8], win_q[7], 8'd0, win_q[5], win_q[4],
				8'd0, win_q[2], win_q[1]};
			if (!last_s1) begin
				win_next = {v_s1, 8'd0, 8'd0, b_cur, 8'd0, 8'd0, a_cur, 8'd0, 8'd0};
			end
			emit = ge2_s1;
		end else begin
			win_next = {v_s1, win_q[8], win_q[7], b_cur, win_q[5], win_q[4],
				a_cur, win_q[2], win_q[1]};
			conv_in  = win_next;
			emit     = ge1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (proc) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			filtered_q   <= csmr_pkg::convolve(kernel_select_q, conv_in);
			frame_last_q <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_pixel = filtered_q;
	assign frame_last     = frame_last_q;

	`CSMR_ASSERT(a_hold_on_block, (out_valid && out_stall) |-> in_stall, "input taken while result blocked")
	`CSMR_ASSERT(a_fwd_col_zero, fwd_s1 |-> (c_s1 == '0), "row store bypass on a non-zero column")
	`CSMR_ASSERT_ALWAYS(a_last_first, (valid_s1 && last_s1) |-> first_s1, "frame end off the first column")
	`CSMR_ASSERT(a_emit_shown, (proc && emit) |=> out_valid, "result of a filtered beat lost")

endmodule
